@@ rtl/core/wspq_pkg.sv @@
package wspq_pkg;

    // Field widths fixed by the interface
    localparam int GRADE_W      = 10;
    localparam int COURSE_W     = 8;
    localparam int KEY_W        = 20;
    localparam int FRONT_KEY_W  = 19;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 10;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_PAYLOAD_W = 32;

    // Depth of the queue between the front and back parts
    localparam int OP_FIFO_DEPTH = 2;

    // Register reset values
    localparam logic [GRADE_W-1:0]  GRADE_LIMIT_RST  = 10'd160;
    localparam logic [COURSE_W-1:0] COURSE_TOTAL_RST = 8'd40;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRADE_LIMIT  = 2'd0,
        REG_COURSE_TOTAL = 2'd1
    } t_cfg_reg;

    // Classified operation handed from front to back
    typedef struct packed {
        t_kind                kind;
        logic [GRADE_W-1:0]   grade;
        logic [COURSE_W-1:0]  courses;
        logic [KEY_W-1:0]     key;
    } t_op;

endpackage

@@ rtl/core/wspq_front.sv @@
module wspq_front #(
    parameter int PAYLOAD_W = wspq_pkg::DEF_PAYLOAD_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_kind,
    input  logic [PAYLOAD_W-1:0]           i_payload,
    input  logic [wspq_pkg::GRADE_W-1:0]   i_average_grade,
    input  logic [wspq_pkg::COURSE_W-1:0]  i_approved_courses,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wspq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wspq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_fifo_full,
    output logic                           o_push,
    output logic [PAYLOAD_W-1:0]           o_push_payload,
    output wspq_pkg::t_op                  o_push_op
);
    import wspq_pkg::*;

    localparam int PROD_W = GRADE_W + COURSE_W;

    logic [GRADE_W-1:0]  r_grade_limit;
    logic [COURSE_W-1:0] r_course_total;

    logic                r_stg_vld;
    t_kind               r_stg_kind;
    logic [PAYLOAD_W-1:0] r_stg_payload;
    logic [GRADE_W-1:0]  r_stg_grade;
    logic [COURSE_W-1:0] r_stg_courses;

    logic                accept;
    logic [GRADE_W-1:0]  clamp_grade;
    logic [COURSE_W-1:0] clamp_courses;
    logic [PROD_W-1:0]   grade_term;
    logic [PROD_W-1:0]   course_term;
    logic [PROD_W:0]     key_sum;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grade_limit  <= GRADE_LIMIT_RST;
            r_course_total <= COURSE_TOTAL_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_GRADE_LIMIT:  r_grade_limit  <= i_cfg_data[GRADE_W-1:0];
                REG_COURSE_TOTAL: r_course_total <= i_cfg_data[COURSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept a transaction while the stage is free or drains this cycle
    assign o_busy = r_stg_vld && i_fifo_full;
    assign accept = i_start && !o_busy;
    assign o_push = r_stg_vld && !i_fifo_full;

    // Clamp the grade and course count to their configured maximums
    assign clamp_grade   = (i_average_grade > r_grade_limit) ? r_grade_limit : i_average_grade;
    assign clamp_courses = (i_approved_courses > r_course_total) ?
                           r_course_total : i_approved_courses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
        end else if (accept) begin
            r_stg_vld <= 1'b1;
        end else if (o_push) begin
            r_stg_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stg_kind    <= t_kind'(i_kind);
            r_stg_payload <= i_payload;
            r_stg_grade   <= clamp_grade;
            r_stg_courses <= clamp_courses;
        end
    end

    // Key: grade*course_total + courses*grade_limit
    assign grade_term  = PROD_W'(r_stg_grade) * PROD_W'(r_course_total);
    assign course_term = PROD_W'(r_stg_courses) * PROD_W'(r_grade_limit);
    assign key_sum     = {1'b0, grade_term} + {1'b0, course_term};

    always_comb begin
        o_push_payload    = r_stg_payload;
        o_push_op.kind    = r_stg_kind;
        o_push_op.grade   = r_stg_grade;
        o_push_op.courses = r_stg_courses;
        o_push_op.key     = KEY_W'(key_sum);
    end

endmodule

@@ rtl/core/wspq_fifo.sv @@
module wspq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wspq_pkg::OP_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_rd_data = r_slot[r_rd_ptr];

    // Store the incoming transaction
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/wspq_back.sv @@
module wspq_back #(
    parameter int CAPACITY  = wspq_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_W = wspq_pkg::DEF_PAYLOAD_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic [PAYLOAD_W-1:0]             i_payload,
    input  wspq_pkg::t_op                    i_op,
    output logic                             o_done,
    output logic [PAYLOAD_W-1:0]             o_front_payload,
    output logic [wspq_pkg::GRADE_W-1:0]     o_front_grade,
    output logic [wspq_pkg::COURSE_W-1:0]    o_front_courses,
    output logic [wspq_pkg::FRONT_KEY_W-1:0] o_front_key,
    output logic [$clog2(CAPACITY+1)-1:0]    o_entry_count,
    output logic                             o_is_empty,
    output logic                             o_rejected
);
    import wspq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Sorted entry cells, front at index 0
    logic [PAYLOAD_W-1:0] r_pay     [CAPACITY];
    logic [GRADE_W-1:0]   r_grade   [CAPACITY];
    logic [COURSE_W-1:0]  r_courses [CAPACITY];
    logic [KEY_W-1:0]     r_key     [CAPACITY];
    logic [CNT_W-1:0]     r_count;

    logic [PAYLOAD_W-1:0] n_pay     [CAPACITY];
    logic [GRADE_W-1:0]   n_grade   [CAPACITY];
    logic [COURSE_W-1:0]  n_courses [CAPACITY];
    logic [KEY_W-1:0]     n_key     [CAPACITY];
    logic [CNT_W-1:0]     n_count;

    logic                 r_done;
    logic [PAYLOAD_W-1:0] r_res_payload;
    logic [GRADE_W-1:0]   r_res_grade;
    logic [COURSE_W-1:0]  r_res_courses;
    logic [FRONT_KEY_W-1:0] r_res_key;
    logic                 r_res_rej;

    logic [CAPACITY-1:0]  ge;
    logic                 q_full;
    logic                 q_empty;
    logic                 do_enq;
    logic                 do_deq;
    logic                 rej;
    logic                 n_empty;

    assign q_full  = (r_count == CNT_W'(CAPACITY));
    assign q_empty = (r_count == '0);
    assign do_enq  = i_vld && (i_op.kind == KIND_ENQ) && !q_full;
    assign do_deq  = i_vld && (i_op.kind == KIND_DEQ) && !q_empty;
    assign rej     = i_vld && !do_enq && !do_deq;

    // Each held cell compares its key with the new one
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i] = (CNT_W'(i) < r_count) && (r_key[i] >= i_op.key);
        end
    end

    // Insert behind equal or higher keys, or shift everything forward on removal
    always_comb begin
        n_pay     = r_pay;
        n_grade   = r_grade;
        n_courses = r_courses;
        n_key     = r_key;
        n_count   = r_count;
        if (do_enq) begin
            if (!ge[0]) begin
                n_pay[0]     = i_payload;
                n_grade[0]   = i_op.grade;
                n_courses[0] = i_op.courses;
                n_key[0]     = i_op.key;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (!ge[i]) begin
                    if (ge[i-1]) begin
                        n_pay[i]     = i_payload;
                        n_grade[i]   = i_op.grade;
                        n_courses[i] = i_op.courses;
                        n_key[i]     = i_op.key;
                    end else begin
                        n_pay[i]     = r_pay[i-1];
                        n_grade[i]   = r_grade[i-1];
                        n_courses[i] = r_courses[i-1];
                        n_key[i]     = r_key[i-1];
                    end
                end
            end
            n_count = r_count + 1'b1;
        end else if (do_deq) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_pay[i]     = r_pay[i+1];
                n_grade[i]   = r_grade[i+1];
                n_courses[i] = r_courses[i+1];
                n_key[i]     = r_key[i+1];
            end
            n_count = r_count - 1'b1;
        end
    end

    assign n_empty = (n_count == '0);

    always_ff @(posedge i_clk) begin
        r_pay     <= n_pay;
        r_grade   <= n_grade;
        r_courses <= n_courses;
        r_key     <= n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_vld;
        end
    end

    // Capture the front of the queue after the operation
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_res_payload <= n_empty ? '0 : n_pay[0];
            r_res_grade   <= n_empty ? '0 : n_grade[0];
            r_res_courses <= n_empty ? '0 : n_courses[0];
            r_res_key     <= n_empty ? '0 : n_key[0][FRONT_KEY_W-1:0];
            r_res_rej     <= rej;
        end
    end

    assign o_done          = r_done;
    assign o_front_payload = r_res_payload;
    assign o_front_grade   = r_res_grade;
    assign o_front_courses = r_res_courses;
    assign o_front_key     = r_res_key;
    assign o_entry_count   = r_count;
    assign o_is_empty      = (r_count == '0);
    assign o_rejected      = r_res_rej;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res_rej) |-> (r_count == $past(r_count)))
        else $error("rejected transaction changed the entry count");

    a_step_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_vld) |-> (r_count == $past(r_count)))
        else $error("entry count moved without a transaction");

    a_sorted_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (r_key[0] >= r_key[1]))
        else $error("front entries out of priority order");
`endif

endmodule

@@ rtl/core/weighted_sorted_priority_queue.sv @@
// Weighted sorted priority queue.
// Input channel: a transaction (i_kind, i_payload, i_average_grade,
// i_approved_courses) is taken at a clock edge with i_start high and o_busy
// low. Kind enqueue inserts an entry behind all entries of equal or higher
// key; kind dequeue removes the front entry.
// Result channel: o_done is high for one cycle per transaction and carries
// the front entry after the operation, the entry count, the empty flag and
// o_rejected (enqueue when full, dequeue when empty). Results cannot be held
// off by the receiver.
// Configuration: i_cfg_valid/o_cfg_ready write the grade limit (index 0) or
// the course total (index 1); other indexes are ignored. Write only when idle.
// Path: the front stage registers the transaction, the operation queue holds
// it, and the cell array result registers drive o_done; a full queue holds
// the front stage back and raises o_busy.
// Throughput: one transaction per cycle while o_busy is low, set by the insert
// or shift of the sorted cell array in the back part.
// Reset (synchronous, active low) empties the queue, clears the front stage
// and the operation queue, and restores grade limit 160, course total 40.
module weighted_sorted_priority_queue #(
    parameter int CAPACITY      = wspq_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_WIDTH = wspq_pkg::DEF_PAYLOAD_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_kind,
    input  logic [PAYLOAD_WIDTH-1:0]          i_payload,
    input  logic [wspq_pkg::GRADE_W-1:0]      i_average_grade,
    input  logic [wspq_pkg::COURSE_W-1:0]     i_approved_courses,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wspq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wspq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_done,
    output logic [PAYLOAD_WIDTH-1:0]          o_front_payload,
    output logic [wspq_pkg::GRADE_W-1:0]      o_front_grade,
    output logic [wspq_pkg::COURSE_W-1:0]     o_front_courses,
    output logic [wspq_pkg::FRONT_KEY_W-1:0]  o_front_key,
    output logic [$clog2(CAPACITY+1)-1:0]     o_entry_count,
    output logic                              o_is_empty,
    output logic                              o_rejected
);
    import wspq_pkg::*;

    localparam int OP_W   = $bits(t_op);
    localparam int SLOT_W = PAYLOAD_WIDTH + OP_W;

    logic                     push;
    logic [PAYLOAD_WIDTH-1:0] push_payload;
    t_op                      push_op;
    logic                     fifo_full;
    logic                     fifo_empty;
    logic [SLOT_W-1:0]        fifo_rd;
    t_op                      back_op;
    logic [PAYLOAD_WIDTH-1:0] back_payload;

    // Front: configuration, clamping and key computation
    wspq_front #(
        .PAYLOAD_W (PAYLOAD_WIDTH)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_kind             (i_kind),
        .i_payload          (i_payload),
        .i_average_grade    (i_average_grade),
        .i_approved_courses (i_approved_courses),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_fifo_full        (fifo_full),
        .o_push             (push),
        .o_push_payload     (push_payload),
        .o_push_op          (push_op)
    );

    // Short queue between front and back
    wspq_fifo #(
        .WIDTH (SLOT_W),
        .DEPTH (OP_FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data ({push_payload, push_op}),
        .i_pop     (!fifo_empty),
        .o_rd_data (fifo_rd),
        .o_full    (fifo_full),
        .o_empty   (fifo_empty)
    );

    assign back_payload = fifo_rd[SLOT_W-1:OP_W];
    assign back_op      = t_op'(fifo_rd[OP_W-1:0]);

    // Back: sorted cell array, executes one operation per cycle
    wspq_back #(
        .CAPACITY  (CAPACITY),
        .PAYLOAD_W (PAYLOAD_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (!fifo_empty),
        .i_payload       (back_payload),
        .i_op            (back_op),
        .o_done          (o_done),
        .o_front_payload (o_front_payload),
        .o_front_grade   (o_front_grade),
        .o_front_courses (o_front_courses),
        .o_front_key     (o_front_key),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_rejected      (o_rejected)
    );

endmodule
